@@ rtl/perspective_texel_address_generator_top_defines.svh @@
// Assertion macros used by the port-level checker file rtl/ptag_checker.sv.
`ifndef PERSPECTIVE_TEXEL_ADDRESS_GENERATOR_TOP_DEFINES_SVH
`define PERSPECTIVE_TEXEL_ADDRESS_GENERATOR_TOP_DEFINES_SVH

// Condition a implies b at the same clock edge.
`define PTAG_CHK_NOW(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// Condition a implies b at the next clock edge.
`define PTAG_CHK_NEXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

@@ rtl/ptag_pkg.sv @@
// Shared constants and types for the perspective texel address generator.
package ptag_pkg;

  localparam int DATA_W          = 32;
  localparam int FADE_W          = 8;
  localparam int FADE_LSB        = 8;
  localparam int TEX_LOG2_DEF    = 6;
  localparam int DEPTH_SHIFT_DEF = 18;
  localparam int CFG_IDX_W       = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_U_STEP     = 2'd0,
    REG_V_STEP     = 2'd1,
    REG_Z_STEP     = 2'd2,
    REG_LIGHT_STEP = 2'd3
  } cfg_reg_t;

  // One request as it travels down the divider chain.
  typedef struct packed {
    logic              draw;
    logic              neg_u;
    logic              neg_v;
    logic [FADE_W-1:0] fade;
    logic [DATA_W-1:0] div;
    logic [DATA_W-1:0] rem_u;
    logic [DATA_W-1:0] rem_v;
    logic [DATA_W-1:0] num_u;
    logic [DATA_W-1:0] num_v;
    logic [DATA_W-1:0] q_u;
    logic [DATA_W-1:0] q_v;
  } stage_t;

endpackage

@@ rtl/ptag_cell.sv @@
// One divider cell: develops one quotient bit of u and of v per request.
module ptag_cell import ptag_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   advance,
  input  logic   valid_in,
  input  stage_t data_in,
  output logic   valid_out,
  output stage_t data_out
);

  logic [DATA_W:0] trial_u, trial_v, div_ext;
  logic            fit_u, fit_v;
  stage_t          data_next;

  always_comb begin
    div_ext = {1'b0, data_in.div};
    trial_u = {data_in.rem_u, data_in.num_u[DATA_W-1]};
    trial_v = {data_in.rem_v, data_in.num_v[DATA_W-1]};
    fit_u   = trial_u >= div_ext;
    fit_v   = trial_v >= div_ext;
    data_next       = data_in;
    data_next.num_u = {data_in.num_u[DATA_W-2:0], 1'b0};
    data_next.num_v = {data_in.num_v[DATA_W-2:0], 1'b0};
    data_next.rem_u = fit_u ? DATA_W'(trial_u - div_ext) : trial_u[DATA_W-1:0];
    data_next.rem_v = fit_v ? DATA_W'(trial_v - div_ext) : trial_v[DATA_W-1:0];
    data_next.q_u   = {data_in.q_u[DATA_W-2:0], fit_u};
    data_next.q_v   = {data_in.q_v[DATA_W-2:0], fit_v};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (advance) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      data_out <= data_next;
    end
  end

endmodule

@@ rtl/ptag_front.sv @@
// Span state: step registers, running accumulators and divider launch.
module ptag_front import ptag_pkg::*; #(
  parameter int DEPTH_SHIFT = DEPTH_SHIFT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  input  logic                 accept,
  input  logic                 action,
  input  logic [DATA_W-1:0]    u_start,
  input  logic [DATA_W-1:0]    v_start,
  input  logic [DATA_W-1:0]    z_start,
  input  logic [DATA_W-1:0]    light_start,
  output stage_t               launch
);

  logic [DATA_W-1:0] u_step, v_step, z_step, light_step;
  logic [DATA_W-1:0] u_acc, v_acc, z_acc, light_acc;
  logic              span_stopped;

  logic [DATA_W-1:0] u_cur, v_cur, z_cur, light_cur, depth;
  logic              stopped_cur, live, neg_d;

  always_comb begin
    u_cur       = action ? u_acc : u_start;
    v_cur       = action ? v_acc : v_start;
    z_cur       = action ? z_acc : z_start;
    light_cur   = action ? light_acc : light_start;
    stopped_cur = action ? span_stopped : 1'b0;
    depth       = DATA_W'($signed(z_cur) >>> DEPTH_SHIFT);
    live        = !stopped_cur && (depth != '0);
    neg_d       = depth[DATA_W-1];

    launch       = '0;
    launch.draw  = live;
    launch.neg_u = u_cur[DATA_W-1] ^ neg_d;
    launch.neg_v = v_cur[DATA_W-1] ^ neg_d;
    launch.fade  = live ? light_cur[FADE_LSB+FADE_W-1:FADE_LSB] : '0;
    // keep a nonzero divisor when the pixel is not drawn
    launch.div   = live ? (neg_d ? DATA_W'(-depth) : depth) : DATA_W'(1);
    launch.num_u = u_cur[DATA_W-1] ? DATA_W'(-u_cur) : u_cur;
    launch.num_v = v_cur[DATA_W-1] ? DATA_W'(-v_cur) : v_cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      u_step <= '0;
      v_step <= '0;
      z_step <= '0;
      light_step <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_U_STEP:     u_step <= cfg_data;
        REG_V_STEP:     v_step <= cfg_data;
        REG_Z_STEP:     z_step <= cfg_data;
        REG_LIGHT_STEP: light_step <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      u_acc <= '0;
      v_acc <= '0;
      z_acc <= '0;
      light_acc <= '0;
      span_stopped <= 1'b1;
    end else if (accept) begin
      if (live) begin
        u_acc <= u_cur + u_step;
        v_acc <= v_cur + v_step;
        z_acc <= z_cur + z_step;
        light_acc <= light_cur + light_step;
        span_stopped <= 1'b0;
      end else begin
        // hold the loaded values, stop the span
        u_acc <= u_cur;
        v_acc <= v_cur;
        z_acc <= z_cur;
        light_acc <= light_cur;
        span_stopped <= 1'b1;
      end
    end
  end

endmodule

@@ rtl/perspective_texel_address_generator_top.sv @@
// Perspective texel address generator: one pixel per cycle while the output keeps
// draining, computed by the chain of 32 divider cells that each resolve one
// quotient bit of u/depth and v/depth. The chain advances whenever its last
// cell is empty or its result is taken, so a new request is taken every cycle
// while the output keeps draining; no clearing pass follows reset.
module perspective_texel_address_generator_top import ptag_pkg::*; #(
  parameter int TEX_LOG2    = TEX_LOG2_DEF,
  parameter int DEPTH_SHIFT = DEPTH_SHIFT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [DATA_W-1:0]     cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  action,
  input  logic [DATA_W-1:0]     u_start,
  input  logic [DATA_W-1:0]     v_start,
  input  logic [DATA_W-1:0]     z_start,
  input  logic [DATA_W-1:0]     light_start,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2*TEX_LOG2-1:0] texel_index,
  output logic [FADE_W-1:0]     fade_row,
  output logic                  draw
);

  stage_t              stage [DATA_W+1];
  logic   [DATA_W:0]   vld;
  logic                advance, accept;
  logic [TEX_LOG2-1:0] qu, qv;

  assign advance  = !vld[DATA_W] || out_ready;
  assign in_ready = advance;
  assign accept   = in_valid && advance;
  assign vld[0]   = accept;

  ptag_front #(.DEPTH_SHIFT(DEPTH_SHIFT)) u_front (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .accept, .action,
    .u_start, .v_start, .z_start, .light_start, .launch(stage[0])
  );

  for (genvar i = 0; i < DATA_W; i++) begin : g_cell
    ptag_cell u_cell (
      .clk, .rst, .advance,
      .valid_in(vld[i]), .data_in(stage[i]),
      .valid_out(vld[i+1]), .data_out(stage[i+1])
    );
  end

  always_comb begin
    qu = stage[DATA_W].q_u[TEX_LOG2-1:0];
    qv = stage[DATA_W].q_v[TEX_LOG2-1:0];
    if (stage[DATA_W].neg_u) qu = TEX_LOG2'(-qu);
    if (stage[DATA_W].neg_v) qv = TEX_LOG2'(-qv);
  end

  assign out_valid   = vld[DATA_W];
  assign draw        = stage[DATA_W].draw;
  assign fade_row    = stage[DATA_W].fade;
  assign texel_index = stage[DATA_W].draw ? {qv, qu} : '0;

endmodule

@@ rtl/ptag_checker.sv @@
// Port-level checks for the perspective texel address generator.
`include "perspective_texel_address_generator_top_defines.svh"

module ptag_props import ptag_pkg::*; #(
  parameter int TEX_LOG2 = TEX_LOG2_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [2*TEX_LOG2-1:0] texel_index,
  input logic [FADE_W-1:0]     fade_row,
  input logic                  draw
);

  `PTAG_CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
  `PTAG_CHK_NOW(a_blank, out_valid && !draw, texel_index == '0 && fade_row == '0, "blank pixel")
  `PTAG_CHK_NOW(a_ready_empty, !out_valid, in_ready, "request refused with empty output")
  `PTAG_CHK_NOW(a_ready_take, out_valid && out_ready, in_ready, "request refused while draining")

endmodule

bind perspective_texel_address_generator_top ptag_props #(.TEX_LOG2(TEX_LOG2)) u_ptag_props (.*);

@@ test/ptag_checker.sv @@
// Checker for the texel address generator: predicts each pixel and compares.
module ptag_checker import ptag_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 action,
  input  logic [DATA_W-1:0]    u_start,
  input  logic [DATA_W-1:0]    v_start,
  input  logic [DATA_W-1:0]    z_start,
  input  logic [DATA_W-1:0]    light_start,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [11:0]          texel_index,
  input  logic [FADE_W-1:0]    fade_row,
  input  logic                 draw,
  output int                   errors,
  output int                   pending
);

  typedef struct packed {
    logic [11:0]       tex;
    logic [FADE_W-1:0] fade;
    logic              drw;
  } pixel_t;

  logic [DATA_W-1:0] du, dv, dz, dl;
  logic [DATA_W-1:0] acc_u, acc_v, acc_z, acc_l;
  logic              stopped;
  pixel_t            expected_pixels[$];

  assign pending = expected_pixels.size();

  function automatic pixel_t walk_pixel(logic act, logic [DATA_W-1:0] su, sv, sz, sl);
    pixel_t p;
    logic signed [63:0] depth, qu, qv;
    p = '0;
    if (!act) begin
      acc_u = su; acc_v = sv; acc_z = sz; acc_l = sl; stopped = 1'b0;
    end
    if (stopped) return p;
    depth = $signed(acc_z) >>> 18;
    if (depth == 0) begin
      stopped = 1'b1;
      return p;
    end
    // Signed divide in SV truncates toward zero; 64 bits keep min / -1 exact.
    qu = $signed(acc_u) / depth;
    qv = $signed(acc_v) / depth;
    p.tex  = {qv[5:0], qu[5:0]};
    p.fade = acc_l[15:8];
    p.drw  = 1'b1;
    acc_u += du; acc_v += dv; acc_z += dz; acc_l += dl;
    return p;
  endfunction

  always @(posedge clk) begin
    pixel_t e;
    if (rst) begin
      du <= '0; dv <= '0; dz <= '0; dl <= '0;
      acc_u = '0; acc_v = '0; acc_z = '0; acc_l = '0;
      stopped = 1'b1;
      errors <= 0;
      expected_pixels.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_U_STEP:     du <= cfg_data;
          REG_V_STEP:     dv <= cfg_data;
          REG_Z_STEP:     dz <= cfg_data;
          REG_LIGHT_STEP: dl <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_pixels.push_back(walk_pixel(action, u_start, v_start, z_start, light_start));
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected pixel tex=%h fade=%h draw=%b", $time, texel_index,
                   fade_row, draw);
          errors <= errors + 1;
        end else begin
          e = expected_pixels.pop_front();
          if (e.tex !== texel_index || e.fade !== fade_row || e.drw !== draw) begin
            $display("%0t: mismatch expected tex=%h fade=%h draw=%b actual tex=%h fade=%h draw=%b",
                     $time, e.tex, e.fade, e.drw, texel_index, fade_row, draw);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

@@ test/tb.sv @@
// Testbench top: stimulus, stalls and verdict for the texel address generator.
module tb;
  import ptag_pkg::*;

  logic                 clk = 0;
  logic                 rst = 1;
  logic                 cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_U_STEP;
  logic [DATA_W-1:0]    cfg_data = '0;
  logic                 in_valid = 0;
  logic                 in_ready;
  logic                 action = 1;
  logic [DATA_W-1:0]    u_start = '0, v_start = '0, z_start = '0, light_start = '0;
  logic                 out_valid;
  logic                 out_ready = 0;
  logic [11:0]          texel_index;
  logic [FADE_W-1:0]    fade_row;
  logic                 draw;
  int                   errors, pending;
  int                   send_idle = 0, recv_idle = 0;
  int                   hold_off = 0;
  int                   cycles = 0;

  always #4 clk = ~clk;

  perspective_texel_address_generator_top dut (.*);
  ptag_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: random stall, plus a long hold-off counted here.
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else out_ready <= ($urandom_range(99) >= recv_idle);
  end

  function automatic logic [31:0] edge_val();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic write_reg(cfg_reg_t r, logic [31:0] d);
    cfg_we <= 1; cfg_index <= r; cfg_data <= d;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic set_steps(logic [31:0] a, b, c, d);
    write_reg(REG_U_STEP, a); write_reg(REG_V_STEP, b);
    write_reg(REG_Z_STEP, c); write_reg(REG_LIGHT_STEP, d);
  endtask

  // Valid stays up after the accept; the next request replaces or drops it, or drain() drops it.
  task automatic send_pixel(logic act, logic [31:0] su, sv, sz, sl);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; action <= act;
    u_start <= su; v_start <= sv; z_start <= sz; light_start <= sl;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Span: start with a usable depth (or at times an edge value), then a run of pixels.
  task automatic random_span(int len);
    logic [31:0] z;
    z = ($urandom_range(3) == 0) ? edge_val() : $urandom_range(32'h3fff_ffff, 32'h4_0000);
    if ($urandom_range(1)) z = -z;
    send_pixel(0, $urandom, $urandom, z, $urandom);
    repeat (len) send_pixel(1, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic random_phase(int n);
    int sent;
    sent = 0;
    while (sent < n) begin
      int len;
      len = $urandom_range(12);
      if ($urandom_range(9) == 0) begin
        send_pixel($urandom_range(1), edge_val(), edge_val(), edge_val(), edge_val());
        sent++;
      end else begin
        random_span(len);
        sent += len + 1;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Stopped after reset, then extremes, zero depth, negative depth.
    send_pixel(1, 0, 0, 0, 0);
    send_pixel(0, 32'h7fff_ffff, 32'h8000_0000, 32'h0004_0000, 32'hffff_ffff);
    send_pixel(1, 0, 0, 0, 0);
    send_pixel(0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_ff00);
    send_pixel(0, 32'h1234_5678, 32'hfedc_ba98, 32'hfffc_0000, 32'h0);
    send_pixel(0, 32'hffff_ffff, 32'h1, 32'hffff_ffff, 32'h7fff_ffff);
    send_pixel(0, 32'h1, 32'h2, 32'h0003_ffff, 32'h1);
    send_pixel(1, 0, 0, 0, 0);
    drain();
    set_steps(32'h7fff_ffff, 32'h8000_0000, 32'hfffc_0000, 32'h0000_0100);
    send_pixel(0, 32'h7fff_0000, 32'h0, 32'h000c_0000, 32'h0);
    repeat (6) send_pixel(1, 0, 0, 0, 0);
    drain();
    set_steps(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff);
    send_pixel(0, 32'h0, 32'h0, 32'h0010_0000, 32'h8000_0000);
    repeat (4) send_pixel(1, 0, 0, 0, 0);
    drain();

    send_idle = 18; recv_idle = 64;
    set_steps($urandom, $urandom, $urandom_range(32'h1_0000), $urandom);
    random_phase(500);
    // Hold the output off while requests keep coming.
    hold_off = 200;
    random_phase(100);
    drain();
    send_idle = 64; recv_idle = 18;
    set_steps(edge_val(), edge_val(), -$urandom_range(32'h1_0000), edge_val());
    random_phase(500);
    drain();
    send_idle = 0; recv_idle = 0;
    set_steps($urandom, $urandom, $urandom, $urandom);
    random_phase(500);
    drain();

    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/ptag_pkg.sv
rtl/ptag_cell.sv
rtl/ptag_front.sv
rtl/perspective_texel_address_generator_top.sv
rtl/ptag_checker.sv
test/ptag_checker.sv
test/tb.sv
